>>> src/cold_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CAN object-list decoder package
// Shared types, constants, tables and helper functions.
// ----------------------------------------------------------------------------
package cold_pkg;

  localparam int CORDIC_STEPS  = 16;
  localparam int POS_FRAC_BITS = 7;
  localparam int ACC_W         = 56;
  localparam int ZW            = 34;
  localparam int STEP_W        = $clog2(CORDIC_STEPS + 1);
  localparam int POS_W         = 22;
  localparam int RND_SH        = 32 - POS_FRAC_BITS;
  localparam int CAM_SH        = POS_FRAC_BITS - 4;

  localparam logic [10:0] ID_RADAR_HDR = 11'h550;
  localparam logic [10:0] ID_RADAR_LO  = 11'h551;
  localparam logic [10:0] ID_RADAR_HI  = 11'h55F;
  localparam logic [10:0] ID_CAM_HDR   = 11'h570;
  localparam logic [10:0] ID_CAM_LO    = 11'h571;
  localparam logic [10:0] ID_CAM_HI    = 11'h57F;

  localparam logic [31:0] GAIN_TENTH = 32'd260813150;

  localparam logic [1:0] CFG_LONG_OFF  = 2'd0;
  localparam logic [1:0] CFG_CAM_OFF   = 2'd1;
  localparam logic [1:0] CFG_RADAR_LIM = 2'd2;
  localparam logic [1:0] CFG_CAM_LIM   = 2'd3;

  typedef enum logic [2:0] {
    KIND_RADAR_OBJ   = 3'd0,
    KIND_CAM_OBJ     = 3'd1,
    KIND_RADAR_EMPTY = 3'd2,
    KIND_CAM_EMPTY   = 3'd3,
    KIND_RADAR_OVF   = 3'd4,
    KIND_CAM_OVF     = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FOLD,
    ST_INIT,
    ST_ITER,
    ST_FINISH,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic fold;
    logic init;
    logic iter;
    logic finish;
    logic cam;
  } cmd_t;

  typedef struct packed {
    logic done;
  } status_t;

  function automatic logic [31:0] atan_val(input logic [4:0] i);
    case (i)
      5'd0: atan_val = 32'h20000000;  5'd1: atan_val = 32'h12E4051E;
      5'd2: atan_val = 32'h09FB385B;  5'd3: atan_val = 32'h051111D4;
      5'd4: atan_val = 32'h028B0D43;  5'd5: atan_val = 32'h0145D7E1;
      5'd6: atan_val = 32'h00A2F61E;  5'd7: atan_val = 32'h00517C55;
      5'd8: atan_val = 32'h0028BE53;  5'd9: atan_val = 32'h00145F2F;
      5'd10: atan_val = 32'h000A2F98; 5'd11: atan_val = 32'h000517CC;
      5'd12: atan_val = 32'h00028BE6; 5'd13: atan_val = 32'h000145F3;
      5'd14: atan_val = 32'h0000A2FA; 5'd15: atan_val = 32'h0000517D;
      5'd16: atan_val = 32'h000028BE; 5'd17: atan_val = 32'h0000145F;
      5'd18: atan_val = 32'h00000A30; 5'd19: atan_val = 32'h00000518;
      5'd20: atan_val = 32'h0000028C; 5'd21: atan_val = 32'h00000146;
      5'd22: atan_val = 32'h000000A3; 5'd23: atan_val = 32'h00000051;
      default: atan_val = 32'h0;
    endcase
  endfunction

  function automatic logic signed [POS_W-1:0] sat22(input logic signed [ACC_W-1:0] v);
    if (v > 56'sd2097151) sat22 = 22'sh1FFFFF;
    else if (v < -56'sd2097152) sat22 = -22'sh200000;
    else sat22 = v[POS_W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> src/cold_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CAN object-list decoder controller
// Sequences fold, CORDIC iterations, rounding and result hand-off.
// ----------------------------------------------------------------------------
module cold_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire logic            is_radar_obj,
  input  wire logic            is_cam_obj,
  input  wire logic            is_hdr_out,
  input  wire logic            out_tready,
  output logic                 out_tvalid,
  output cold_pkg::cmd_t       cmd,
  input  wire cold_pkg::status_t sts
);
  import cold_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_tready = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (is_radar_obj) state_nxt = ST_FOLD;
          else if (is_cam_obj) state_nxt = ST_FINISH;
          else if (is_hdr_out) state_nxt = ST_OUT;
        end
      end
      ST_FOLD: begin
        cmd.fold = 1'b1;
        state_nxt = ST_INIT;
      end
      ST_INIT: begin
        cmd.init = 1'b1;
        state_nxt = ST_ITER;
      end
      ST_ITER: begin
        cmd.iter = 1'b1;
        if (sts.done) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("result dropped while stalled");
  assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while result pending");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.init |=> cmd.iter)
    else $error("iteration did not follow init");
endmodule
`default_nettype wire

>>> src/cold_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CAN object-list decoder datapath
// Stream state, registers, CORDIC unit and result register.
// ----------------------------------------------------------------------------
module cold_dp (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire cold_pkg::cmd_t cmd,
  output cold_pkg::status_t  sts,
  input  wire logic [10:0]   can_id,
  input  wire logic [63:0]   bytes_in,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_idx,
  input  wire logic [11:0]   cfg_data,
  output logic               is_radar_obj,
  output logic               is_cam_obj,
  output logic               is_hdr_out,
  output logic [111:0]       res
);
  import cold_pkg::*;

  logic signed [11:0] loff_r;
  logic [10:0] coff_r;
  logic [7:0] rlim_r, clim_r, rrem_r, crem_r;
  logic rarm_r, carm_r;
  logic [2:0] kind_r;
  logic [15:0] w0_r, w1_r, w2_r;
  logic [7:0] b6_r, b7_r;
  logic last_r;
  logic signed [ACC_W-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;
  logic signed [12:0] a_r;
  logic flip_r;
  logic [STEP_W-1:0] step_r;
  logic signed [POS_W-1:0] px_r, py_r;

  logic [15:0] w0, w1;
  logic [7:0] cnt;
  logic is_rh, is_ch, arm;
  assign w0 = bytes_in[63:48];
  assign w1 = bytes_in[47:32];
  assign cnt = bytes_in[63:56];
  assign is_rh = can_id == ID_RADAR_HDR;
  assign is_ch = can_id == ID_CAM_HDR;
  assign arm = (cnt != 8'd0) && (cnt <= (is_rh ? rlim_r : clim_r));
  assign is_radar_obj = rarm_r && can_id >= ID_RADAR_LO && can_id <= ID_RADAR_HI
                        && !is_rh && !is_ch;
  assign is_cam_obj = carm_r && can_id >= ID_CAM_LO && can_id <= ID_CAM_HI;
  assign is_hdr_out = (is_rh || is_ch) && !arm;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loff_r <= '0; coff_r <= 11'd448; rlim_r <= 8'd15; clim_r <= 8'd10;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_LONG_OFF:  loff_r <= cfg_data;
        CFG_CAM_OFF:   coff_r <= cfg_data[10:0];
        CFG_RADAR_LIM: rlim_r <= cfg_data[7:0];
        CFG_CAM_LIM:   clim_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rrem_r <= '0; crem_r <= '0; rarm_r <= 1'b0; carm_r <= 1'b0;
    end else if (cmd.load) begin
      if (is_rh) begin
        rarm_r <= arm; rrem_r <= arm ? cnt : 8'd0;
      end else if (is_ch) begin
        carm_r <= arm; crem_r <= arm ? cnt : 8'd0;
      end else if (is_radar_obj) begin
        rrem_r <= rrem_r - 8'd1;
        if (rrem_r == 8'd1) rarm_r <= 1'b0;
      end else if (is_cam_obj) begin
        crem_r <= crem_r - 8'd1;
        if (crem_r == 8'd1) carm_r <= 1'b0;
      end
    end
  end

  logic signed [12:0] am, af;
  logic fl;
  logic [16:0] av, ar;
  logic [26:0] aprod;
  logic [4:0] aq;
  logic signed [ACC_W-1:0] sx, sy, xs, ys, rx, ry, cx, cy;
  logic [16:0] zw;
  logic [33:0] zprod;
  logic [30:0] zn;
  logic [12:0] mag;
  logic signed [ZW-1:0] zt;
  logic [4:0] si;
  logic [47:0] x0;

  always_comb begin
    // The angle is biased positive, then reduced modulo 3600 with an exact
    // reciprocal multiply on the value divided by 16.
    av = {w1_r[15], w1_r} + 17'd36000;
    aprod = 27'(av[16:4]) * 27'd9321;
    aq = aprod[25:21];
    ar = av - 17'(aq) * 17'd3600;
    am = 13'(ar);
    if (am >= 13'sd1800) am = am - 13'sd3600;
    af = am; fl = 1'b0;
    if (am > 13'sd900) begin af = am - 13'sd1800; fl = 1'b1; end
    else if (am < -13'sd900) begin af = am + 13'sd1800; fl = 1'b1; end
    // Binary angle: mag * 2^28 / 225 rounded, split into whole and remainder parts.
    mag = a_r < 0 ? 13'(-a_r) : 13'(a_r);
    zw = 17'(mag) * 17'd106 + 17'd112;
    zprod = 34'(zw) * 34'd74566;
    zn = 31'(mag) * 31'd1193046 + 31'(zprod[33:24]);
    zt = a_r < 0 ? -ZW'(zn) : ZW'(zn);
    si = 5'(step_r);
    xs = x_r >>> si;
    ys = y_r >>> si;
    x0 = 48'(w0_r) * 48'(GAIN_TENTH);
    rx = (flip_r ? -x_r : x_r) + (ACC_W'(1) <<< (RND_SH - 1));
    ry = (flip_r ? -y_r : y_r) + (ACC_W'(1) <<< (RND_SH - 1));
    cx = (ACC_W'(w0_r) <<< CAM_SH) + ACC_W'(loff_r) + ACC_W'({1'b0, coff_r});
    cy = ACC_W'($signed(w1_r)) <<< CAM_SH;
    sx = (rx >>> RND_SH) + ACC_W'(loff_r);
    sy = ry >>> RND_SH;
  end

  assign sts.done = step_r == STEP_W'(CORDIC_STEPS - 1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w0_r <= w0; w1_r <= w1; w2_r <= bytes_in[31:16];
      b6_r <= bytes_in[15:8]; b7_r <= bytes_in[7:0];
      kind_r <= is_rh ? (cnt == 0 ? KIND_RADAR_EMPTY : KIND_RADAR_OVF)
              : is_ch ? (cnt == 0 ? KIND_CAM_EMPTY : KIND_CAM_OVF)
              : is_radar_obj ? KIND_RADAR_OBJ : KIND_CAM_OBJ;
      last_r <= is_radar_obj ? rrem_r == 8'd1 : crem_r == 8'd1;
      px_r <= '0; py_r <= '0;
    end
    if (cmd.fold) begin a_r <= af; flip_r <= fl; end
    if (cmd.init) begin
      z_r <= zt; step_r <= '0; y_r <= '0;
      x_r <= ACC_W'(x0);
    end
    if (cmd.iter) begin
      step_r <= step_r + STEP_W'(1);
      if (z_r >= 0) begin
        x_r <= x_r - ys; y_r <= y_r + xs; z_r <= z_r - ZW'(atan_val(si));
      end else begin
        x_r <= x_r + ys; y_r <= y_r - xs; z_r <= z_r + ZW'(atan_val(si));
      end
    end
    if (cmd.finish) begin
      px_r <= sat22(cmd.cam ? cx : sx);
      py_r <= sat22(cmd.cam ? cy : sy);
    end
  end

  logic obj, cam;
  assign obj = kind_r == KIND_RADAR_OBJ || kind_r == KIND_CAM_OBJ;
  assign cam = kind_r == KIND_CAM_OBJ;
  assign res = {last_r & obj, cam ? b7_r : 8'd0, cam ? b6_r : 8'd0,
                (obj && !cam) ? w1_r : 16'd0, (obj && !cam) ? w0_r : 16'd0,
                obj ? w2_r : 16'd0, py_r, px_r, kind_r};
endmodule
`default_nettype wire

>>> src/can_object_list_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CAN object-list decoder
// Decodes radar and camera object-list frames into position results.
// ----------------------------------------------------------------------------
// The input channel takes one CAN frame per transaction: the identifier and
// eight data bytes. The output channel delivers zero or one result per frame.
// Radar objects pass through a load, an angle fold, a CORDIC setup, 16
// CORDIC iterations in one shared shift-add unit and a rounding step.
// Camera objects go from the load to the rounding step, and header results
// are valid in the cycle after the load; no-result frames keep in_tready.
// One frame is processed at a time; the next is accepted in the cycle after
// its result transaction. If the receiver stalls, the result holds and the
// input stays not ready. Reset clears both streams to waiting for a header
// and loads the register defaults.
// The configuration port writes one register per cycle with cfg_we.
// ----------------------------------------------------------------------------
module can_object_list_decoder (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // can_id[10:0], byte0..byte7 at [18:11]..[74:67], zero padded
  input  wire logic [79:0]  in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // pos_x, pos_y, velocity_raw, range_raw, bearing_raw, track_id,
  // target_class, zero padded
  output logic [111:0]      out_tdata,
  // kind
  output logic [2:0]        out_tuser,
  output logic              out_tlast,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_idx,
  input  wire logic [11:0]  cfg_data
);
  import cold_pkg::*;

  cmd_t c, cmd;
  status_t sts;
  logic ro, co, ho;
  logic cam_r;
  logic [63:0] bts;
  logic [111:0] res;

  assign bts = {in_tdata[18:11], in_tdata[26:19], in_tdata[34:27], in_tdata[42:35],
                in_tdata[50:43], in_tdata[58:51], in_tdata[66:59], in_tdata[74:67]};

  assign out_tuser = res[2:0];
  assign out_tdata = {4'd0, res[110:3]};
  assign out_tlast = res[111];

  always_ff @(posedge clk) begin
    if (c.load) cam_r <= co;
  end

  always_comb begin
    cmd = c;
    cmd.cam = cam_r;
  end

  cold_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready,
    .is_radar_obj(ro), .is_cam_obj(co), .is_hdr_out(ho),
    .out_tready, .out_tvalid, .cmd(c), .sts
  );

  cold_dp u_dp (
    .clk, .rst_n, .cmd, .sts,
    .can_id(in_tdata[10:0]), .bytes_in(bts),
    .cfg_we, .cfg_idx, .cfg_data,
    .is_radar_obj(ro), .is_cam_obj(co), .is_hdr_out(ho),
    .res(res)
  );
endmodule
`default_nettype wire

>>> test/tb_can_object_list_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN object-list decoder testbench
// Drives radar and camera frame streams through the block, predicts every
// decoded object, empty-cycle and overflow result in a scoreboard, and
// checks each output transaction field by field under random stalls.
// ----------------------------------------------------------------------------
import cold_pkg::*;

typedef struct {
  kind_t               kind;
  logic signed [21:0]  pos_x;
  logic signed [21:0]  pos_y;
  logic [15:0]         velocity;
  logic [15:0]         range_w;
  logic [15:0]         bearing;
  logic [7:0]          track;
  logic [7:0]          tclass;
  logic                last;
} obj_result_t;

class object_scoreboard;
  obj_result_t expected_q[$];
  int          errors;
  logic signed [11:0] long_off;
  logic [10:0] cam_off;
  logic [7:0]  radar_lim;
  logic [7:0]  cam_lim;
  logic [7:0]  radar_left;
  logic [7:0]  cam_left;
  bit          radar_armed;
  bit          cam_armed;
  longint      atan_lut[16] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};

  function new();
    errors = 0;
    long_off = 0;
    cam_off = 11'd448;
    radar_lim = 8'd15;
    cam_lim = 8'd10;
    radar_left = 0;
    cam_left = 0;
    radar_armed = 0;
    cam_armed = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [11:0] val);
    case (idx)
      CFG_LONG_OFF:  long_off = val;
      CFG_CAM_OFF:   cam_off = val[10:0];
      CFG_RADAR_LIM: radar_lim = val[7:0];
      default:       cam_lim = val[7:0];
    endcase
  endfunction

  function longint clamp22(longint v);
    if (v > 64'sd2097151) return 64'sd2097151;
    if (v < -64'sd2097152) return -64'sd2097152;
    return v;
  endfunction

  function void polar_to_xy(logic [15:0] rng, logic signed [15:0] ang,
                            output longint px, output longint py);
    longint a, mag, x, y, z, nx;
    bit flip;
    flip = 0;
    a = ((longint'(ang) % 3600) + 3600) % 3600;
    if (a >= 1800) a -= 3600;
    if (a > 900) begin
      a -= 1800;
      flip = 1;
    end else if (a < -900) begin
      a += 1800;
      flip = 1;
    end
    mag = (a < 0) ? -a : a;
    z = ((mag <<< 32) + 1800) / 3600;
    if (a < 0) z = -z;
    x = longint'(rng) * 64'sd260813150;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_lut[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_lut[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    px = (x + (64'sd1 <<< 24)) >>> 25;
    py = (y + (64'sd1 <<< 24)) >>> 25;
  endfunction

  function void note_frame(logic [79:0] d);
    logic [10:0] id;
    logic [7:0]  b[8];
    logic [15:0] w0, w1, w2;
    obj_result_t r;
    longint px, py;
    bit radar, arm;
    logic [7:0] lim;
    id = d[10:0];
    for (int i = 0; i < 8; i++) b[i] = d[11 + 8*i +: 8];
    w0 = {b[0], b[1]};
    w1 = {b[2], b[3]};
    w2 = {b[4], b[5]};
    r = '{kind: KIND_RADAR_OBJ, default: '0};
    if (id == ID_RADAR_HDR || id == ID_CAM_HDR) begin
      radar = (id == ID_RADAR_HDR);
      lim = radar ? radar_lim : cam_lim;
      arm = (b[0] != 0) && (b[0] <= lim);
      if (radar) begin
        radar_armed = arm;
        radar_left = arm ? b[0] : 8'd0;
      end else begin
        cam_armed = arm;
        cam_left = arm ? b[0] : 8'd0;
      end
      if (arm) return;
      if (b[0] == 0) r.kind = radar ? KIND_RADAR_EMPTY : KIND_CAM_EMPTY;
      else r.kind = radar ? KIND_RADAR_OVF : KIND_CAM_OVF;
      expected_q.insert(expected_q.size(), r);
    end else if (radar_armed && id >= ID_RADAR_LO && id <= ID_RADAR_HI) begin
      polar_to_xy(w0, w1, px, py);
      radar_left--;
      if (radar_left == 0) radar_armed = 0;
      r.kind = KIND_RADAR_OBJ;
      r.pos_x = clamp22(px + longint'(long_off));
      r.pos_y = clamp22(py);
      r.velocity = w2;
      r.range_w = w0;
      r.bearing = w1;
      r.last = !radar_armed;
      expected_q.insert(expected_q.size(), r);
    end else if (cam_armed && id >= ID_CAM_LO && id <= ID_CAM_HI) begin
      px = longint'(w0) * 8 + longint'(long_off) + longint'(cam_off);
      py = longint'(signed'(w1)) * 8;
      cam_left--;
      if (cam_left == 0) cam_armed = 0;
      r.kind = KIND_CAM_OBJ;
      r.pos_x = clamp22(px);
      r.pos_y = clamp22(py);
      r.velocity = w2;
      r.track = b[6];
      r.tclass = b[7];
      r.last = !cam_armed;
      expected_q.insert(expected_q.size(), r);
    end
  endfunction

  function void check_result(logic [2:0] u, logic [111:0] d, logic l);
    obj_result_t e;
    obj_result_t a;
    a.kind = kind_t'(u);
    a.pos_x = d[21:0];
    a.pos_y = d[43:22];
    a.velocity = d[59:44];
    a.range_w = d[75:60];
    a.bearing = d[91:76];
    a.track = d[99:92];
    a.tclass = d[107:100];
    a.last = l;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("Unexpected result transaction: %p", a);
      return;
    end
    e = expected_q.pop_front();
    if (a.kind !== e.kind || a.pos_x !== e.pos_x || a.pos_y !== e.pos_y ||
        a.velocity !== e.velocity || a.range_w !== e.range_w ||
        a.bearing !== e.bearing || a.track !== e.track ||
        a.tclass !== e.tclass || a.last !== e.last) begin
      errors++;
      if (errors <= 10) $display("Mismatch: expected %p, actual %p", e, a);
    end
  endfunction
endclass

module tb_can_object_list_decoder;
  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [79:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [111:0] out_tdata;
  logic [2:0]   out_tuser;
  logic         out_tlast;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_idx = CFG_LONG_OFF;
  logic [11:0]  cfg_data = '0;

  object_scoreboard sb = new();
  bit quiet = 0;
  int frames_sent = 0;
  int stall_cycles = 0;

  can_object_list_decoder DUT (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 24);
    if (rst_n && in_tvalid && in_tready) sb.note_frame(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata, out_tlast);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > 5000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_frame(logic [10:0] id, logic [15:0] w0, logic [15:0] w1,
                            logic [15:0] w2, logic [7:0] b6, logic [7:0] b7);
    while (!quiet && $urandom_range(99) < 24) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'd0, b7, b6, w2[7:0], w2[15:8], w1[7:0], w1[15:8],
                 w0[7:0], w0[15:8], id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    frames_sent++;
  endtask

  task automatic send_header(logic [10:0] id, logic [7:0] count);
    send_frame(id, {count, 8'($urandom)}, 16'($urandom), 16'($urandom),
               8'($urandom), 8'($urandom));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_regs(logic signed [11:0] off, logic [10:0] cam,
                            logic [7:0] rlim, logic [7:0] clim);
    logic [11:0] vals[4];
    vals = '{off, {1'b0, cam}, {4'd0, rlim}, {4'd0, clim}};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= 2'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      sb.set_reg(2'(i), vals[i]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_angle();
    int r;
    r = $urandom_range(9);
    if (r < 5) return 16'($urandom);
    if (r < 8) return 16'($urandom_range(3600) - 1800);
    case ($urandom_range(5))
      0: return 16'(900);
      1: return 16'(-900);
      2: return 16'(1800);
      3: return 16'(-1800);
      4: return 16'(901);
      default: return 16'(3600);
    endcase
  endfunction

  task automatic random_cycle(bit radar, bit full);
    logic [7:0] lim;
    int r, count;
    lim = radar ? sb.radar_lim : sb.cam_lim;
    r = $urandom_range(99);
    if (r < 10) count = 0;
    else if (r < 20 && lim < 255) count = $urandom_range(255, lim + 1);
    else if (lim == 0) count = 0;
    else if (full) count = lim;
    else count = $urandom_range(1, (lim > 12) ? 12 : lim);
    send_header(radar ? ID_RADAR_HDR : ID_CAM_HDR, 8'(count));
    if (r < 20) count = $urandom_range(3);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 8)
        send_frame(11'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   8'($urandom), 8'($urandom));
      if ($urandom_range(99) < 3) break;
      if (radar)
        send_frame(11'($urandom_range(ID_RADAR_HI, ID_RADAR_LO)), 16'($urandom),
                   pick_angle(), 16'($urandom), 8'($urandom), 8'($urandom));
      else
        send_frame(11'($urandom_range(ID_CAM_HI, ID_CAM_LO)), 16'($urandom),
                   16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic random_phase(int frames);
    int stop_at;
    stop_at = frames_sent + frames;
    while (frames_sent < stop_at) random_cycle($urandom_range(1), 0);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_header(ID_RADAR_HDR, 8'd0);
    send_header(ID_CAM_HDR, 8'd0);
    send_header(ID_RADAR_HDR, 8'd16);
    send_frame(ID_RADAR_LO, 16'd100, 16'd0, 16'd0, 8'd0, 8'd0);
    send_header(ID_CAM_HDR, 8'd11);
    send_header(ID_RADAR_HDR, 8'd15);
    send_frame(ID_RADAR_LO, 16'd0, 16'd0, 16'h8000, 8'hFF, 8'hFF);
    send_frame(ID_RADAR_HI, 16'hFFFF, 16'd900, 16'h7FFF, 8'd0, 8'd0);
    send_frame(11'h555, 16'hFFFF, 16'hFC7C, 16'd1, 8'd0, 8'd0);
    send_frame(11'h55A, 16'd1000, 16'd901, 16'd0, 8'd0, 8'd0);
    send_frame(11'h552, 16'd1000, 16'd1800, 16'd0, 8'd0, 8'd0);
    send_frame(11'h553, 16'd1000, 16'h8000, 16'd0, 8'd0, 8'd0);
    send_frame(11'h554, 16'hFFFF, 16'h7FFF, 16'd0, 8'd0, 8'd0);
    send_header(ID_RADAR_HDR, 8'd2);
    send_frame(11'h7FF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
    send_frame(ID_RADAR_HI, 16'd500, 16'hF8F8, 16'd5, 8'd0, 8'd0);
    send_frame(ID_RADAR_LO, 16'd500, 16'd3599, 16'd5, 8'd0, 8'd0);
    send_frame(ID_RADAR_LO, 16'd500, 16'd0, 16'd5, 8'd0, 8'd0);
    send_header(ID_CAM_HDR, 8'd10);
    send_frame(ID_CAM_LO, 16'd0, 16'h8000, 16'h8000, 8'd0, 8'd0);
    send_frame(ID_CAM_HI, 16'hFFFF, 16'h7FFF, 16'h7FFF, 8'hFF, 8'hFF);
    send_header(ID_CAM_HDR, 8'd1);
    send_frame(11'h000, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0);
    send_frame(11'h57A, 16'd16, 16'hFFF0, 16'd0, 8'd7, 8'd4);
    drain();

    random_phase(350);
    drain();

    write_regs(-12'sd1280, 11'd1280, 8'd255, 8'd255);
    random_cycle(1, 1);
    random_phase(300);
    drain();

    write_regs(12'sd1280, 11'd0, 8'd0, 8'd0);
    random_phase(80);
    drain();

    write_regs(12'($urandom_range(2560) - 1280), 11'($urandom_range(1280)),
               8'($urandom_range(40)), 8'($urandom_range(40)));
    quiet = 1;
    random_phase(300);
    drain();
    quiet = 0;

    write_regs(12'sd0, 11'd448, 8'd1, 8'd1);
    random_phase(150);
    drain();

    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

>>> files.f
src/cold_pkg.sv
src/cold_ctrl.sv
src/cold_dp.sv
src/can_object_list_decoder.sv
test/tb_can_object_list_decoder.sv
